[design/tdsc_pkg.sv]
// shared types, widths and constants of the tds compensation pipeline
package tdsc_pkg;

    localparam int ADC_BITS_DEF = 10;

    // configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 19;
    localparam int SLOPE_W = 13;
    localparam int TEMP_W = 12;
    localparam int COEF_W = 19;

    // datapath widths
    localparam int X_W = 22;     // adc * 33 scaled to q16 before the divide by ten
    localparam int V_W = 18;     // q16 volts
    localparam int D_W = 13;     // temperature difference
    localparam int P_W = 27;     // slope times temperature difference
    localparam int F_W = 23;     // signed q16 compensation factor
    localparam int DV_W = 22;    // divisor and partial remainder
    localparam int DIV_Q = 20;   // quotient bits
    localparam int Q_FRAC = 16;
    localparam int CV_W = 20;
    localparam int V2_W = 24;
    localparam int V3_W = 28;
    localparam int P1_W = 40;
    localparam int P2_W = 44;
    localparam int P3_W = 48;
    localparam int S_W = 49;
    localparam int PPM_W = 16;
    localparam int PPM_SHIFT = 25;
    localparam int STATUS_W = 2;

    localparam int VOLT_NUM = 33;
    localparam int RECIP_SHIFT = 25;
    localparam logic [X_W-1:0] RECIP_10 = X_W'(3355443);   // floor(2^25 / 10)
    localparam logic [X_W-1:0] TEN = X_W'(10);
    localparam logic signed [F_W-1:0] FACT_ONE = F_W'(65536);
    localparam logic [CV_W-1:0] CV_MAX = '1;
    localparam logic [PPM_W-1:0] PPM_MAX = '1;

    // register reset values
    localparam logic [SLOPE_W-1:0] SLOPE_RST = SLOPE_W'(1311);
    localparam logic signed [TEMP_W-1:0] REF_TEMP_RST = TEMP_W'(400);
    localparam logic signed [COEF_W-1:0] COEF_CUBIC_RST = COEF_W'(34156);
    localparam logic signed [COEF_W-1:0] COEF_SQUARE_RST = COEF_W'(-65500);
    localparam logic signed [COEF_W-1:0] COEF_LINEAR_RST = COEF_W'(219492);

    typedef enum logic [CFG_IW-1:0] {
        CFG_COMP_SLOPE  = 3'd0,
        CFG_REF_TEMP    = 3'd1,
        CFG_COEF_CUBIC  = 3'd2,
        CFG_COEF_SQUARE = 3'd3,
        CFG_COEF_LINEAR = 3'd4
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_NORMAL     = 2'd0,
        ST_CLAMP_ZERO = 2'd1,
        ST_SAT_HIGH   = 2'd2,
        ST_BAD_FACTOR = 2'd3
    } t_status;

    // flags that ride alongside the divider
    typedef struct packed {
        logic err;   // factor not positive
        logic ovf;   // quotient would not fit, saturate
    } t_div_tag;

endpackage

[design/tds_temperature_compensation.sv]
// tds meter with temperature compensation: volts, factor, divide, cubic, clamp
// pipeline: 4 front stages, 20 divider stages, 4 multiply and sum stages and
// 1 output register lie between input transfer and result valid
// throughput: one sample per cycle while the output is ready; a stalled output fills the bubbles first
// reset: synchronous active low, clears all stage valid bits and loads the
// configuration registers with their default calibration
module tds_temperature_compensation #(
    parameter int ADC_BITS = tdsc_pkg::ADC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ADC_BITS-1:0]               i_adc_sample,
    input  logic signed [tdsc_pkg::TEMP_W-1:0] i_water_temp,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [tdsc_pkg::PPM_W-1:0]        o_tds_ppm,
    output logic [tdsc_pkg::STATUS_W-1:0]     o_status,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tdsc_pkg::CFG_IW-1:0]       i_cfg_index,
    input  logic [tdsc_pkg::CFG_DW-1:0]       i_cfg_data
);
    import tdsc_pkg::*;

    localparam int ADC_SHIFT = 16 - ADC_BITS;

    // configuration
    logic [SLOPE_W-1:0]        r_slope;
    logic signed [TEMP_W-1:0]  r_ref_temp;
    logic signed [COEF_W-1:0]  r_coef_cubic;
    logic signed [COEF_W-1:0]  r_coef_square;
    logic signed [COEF_W-1:0]  r_coef_linear;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope       <= SLOPE_RST;
            r_ref_temp    <= REF_TEMP_RST;
            r_coef_cubic  <= COEF_CUBIC_RST;
            r_coef_square <= COEF_SQUARE_RST;
            r_coef_linear <= COEF_LINEAR_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COMP_SLOPE:  r_slope       <= i_cfg_data[SLOPE_W-1:0];
                CFG_REF_TEMP:    r_ref_temp    <= i_cfg_data[TEMP_W-1:0];
                CFG_COEF_CUBIC:  r_coef_cubic  <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_SQUARE: r_coef_square <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_LINEAR: r_coef_linear <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valids and per-stage ready chain
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic r_m1_vld, r_m2_vld, r_m3_vld, r_m4_vld, r_out_vld;
    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, div_in_rdy, div_vld;
    logic m1_rdy, m2_rdy, m3_rdy, m4_rdy, out_rdy;

    assign out_rdy = !r_out_vld || i_out_ready;
    assign m4_rdy  = !r_m4_vld || out_rdy;
    assign m3_rdy  = !r_m3_vld || m4_rdy;
    assign m2_rdy  = !r_m2_vld || m3_rdy;
    assign m1_rdy  = !r_m1_vld || m2_rdy;
    assign s4_rdy  = !r_s4_vld || div_in_rdy;
    assign s3_rdy  = !r_s3_vld || s4_rdy;
    assign s2_rdy  = !r_s2_vld || s3_rdy;
    assign s1_rdy  = !r_s1_vld || s2_rdy;
    assign o_in_ready = s1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_m1_vld  <= 1'b0;
            r_m2_vld  <= 1'b0;
            r_m3_vld  <= 1'b0;
            r_m4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_rdy)  r_s1_vld  <= i_in_valid;
            if (s2_rdy)  r_s2_vld  <= r_s1_vld;
            if (s3_rdy)  r_s3_vld  <= r_s2_vld;
            if (s4_rdy)  r_s4_vld  <= r_s3_vld;
            if (m1_rdy)  r_m1_vld  <= div_vld;
            if (m2_rdy)  r_m2_vld  <= r_m1_vld;
            if (m3_rdy)  r_m3_vld  <= r_m2_vld;
            if (m4_rdy)  r_m4_vld  <= r_m3_vld;
            if (out_rdy) r_out_vld <= r_m4_vld;
        end
    end

    // stage 1: scaled sample and temperature difference
    logic [X_W-1:0]          r_s1_x, n_s1_x;
    logic signed [D_W-1:0]   r_s1_d, n_s1_d;

    always_comb begin
        n_s1_x = (X_W'(i_adc_sample) * X_W'(VOLT_NUM)) << ADC_SHIFT;
        n_s1_d = D_W'(i_water_temp) - D_W'(r_ref_temp);
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_s1_x <= n_s1_x;
            r_s1_d <= n_s1_d;
        end
    end

    // stage 2: reciprocal estimate of x/10 and slope product
    logic [2*X_W-1:0]        q_prod;
    logic [V_W-1:0]          r_s2_q0, n_s2_q0;
    logic [X_W-1:0]          r_s2_x;
    logic signed [P_W-1:0]   r_s2_p, n_s2_p;

    always_comb begin
        q_prod  = (2*X_W)'(r_s1_x) * (2*X_W)'(RECIP_10);
        n_s2_q0 = q_prod[RECIP_SHIFT+V_W-1:RECIP_SHIFT];
        n_s2_p  = P_W'($signed({1'b0, r_slope})) * P_W'(r_s1_d);
    end

    always_ff @(posedge i_clk) begin
        if (s2_rdy) begin
            r_s2_q0 <= n_s2_q0;
            r_s2_x  <= r_s1_x;
            r_s2_p  <= n_s2_p;
        end
    end

    // stage 3: estimate may be one low, fix it; q16 factor with floor shift
    logic [X_W-1:0]          s3_rem;
    logic [V_W-1:0]          r_s3_v, n_s3_v;
    logic signed [F_W-1:0]   r_s3_f, n_s3_f;

    always_comb begin
        s3_rem = r_s2_x - X_W'(r_s2_q0) * TEN;
        n_s3_v = r_s2_q0 + V_W'(s3_rem >= TEN);
        n_s3_f = FACT_ONE + F_W'(r_s2_p >>> 4);
    end

    always_ff @(posedge i_clk) begin
        if (s3_rdy) begin
            r_s3_v <= n_s3_v;
            r_s3_f <= n_s3_f;
        end
    end

    // stage 4: divider set-up, dividend is v shifted up by sixteen
    logic [DV_W-1:0]         r_s4_rem, n_s4_rem;
    logic [DV_W-1:0]         r_s4_dvsr;
    logic [DIV_Q-1:0]        r_s4_feed, n_s4_feed;
    t_div_tag                r_s4_tag, n_s4_tag;

    always_comb begin
        n_s4_rem     = DV_W'(r_s3_v[V_W-1:DIV_Q-Q_FRAC]);
        n_s4_feed    = {r_s3_v[DIV_Q-Q_FRAC-1:0], {Q_FRAC{1'b0}}};
        n_s4_tag.err = r_s3_f[F_W-1] || (r_s3_f == '0);
        n_s4_tag.ovf = n_s4_rem >= r_s3_f[DV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (s4_rdy) begin
            r_s4_rem  <= n_s4_rem;
            r_s4_dvsr <= r_s3_f[DV_W-1:0];
            r_s4_feed <= n_s4_feed;
            r_s4_tag  <= n_s4_tag;
        end
    end

    logic [DIV_Q-1:0] div_quot;
    t_div_tag         div_tag;

    tdsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s4_vld),
        .o_ready (div_in_rdy),
        .i_rem   (r_s4_rem),
        .i_dvsr  (r_s4_dvsr),
        .i_feed  (r_s4_feed),
        .i_tag   (r_s4_tag),
        .o_valid (div_vld),
        .i_ready (m1_rdy),
        .o_quot  (div_quot),
        .o_tag   (div_tag)
    );

    // m1: saturate quotient, square it, linear term
    logic [CV_W-1:0]         m1_cv;
    logic [2*CV_W-1:0]       m1_sq;
    logic [CV_W-1:0]         r_m1_cv;
    logic [V2_W-1:0]         r_m1_v2;
    logic signed [P1_W-1:0]  r_m1_p1, n_m1_p1;
    logic                    r_m1_err;

    always_comb begin
        m1_cv   = div_tag.ovf ? CV_MAX : div_quot[CV_W-1:0];
        m1_sq   = (2*CV_W)'(m1_cv) * (2*CV_W)'(m1_cv);
        n_m1_p1 = P1_W'(r_coef_linear) * P1_W'($signed({1'b0, m1_cv}));
    end

    always_ff @(posedge i_clk) begin
        if (m1_rdy) begin
            r_m1_cv  <= m1_cv;
            r_m1_v2  <= m1_sq[Q_FRAC+V2_W-1:Q_FRAC];
            r_m1_p1  <= n_m1_p1;
            r_m1_err <= div_tag.err;
        end
    end

    // m2: cube and square term
    logic [V2_W+CV_W-1:0]    m2_cube;
    logic [V3_W-1:0]         r_m2_v3;
    logic signed [P1_W-1:0]  r_m2_p1;
    logic signed [P2_W-1:0]  r_m2_p2, n_m2_p2;
    logic                    r_m2_err;

    always_comb begin
        m2_cube = (V2_W+CV_W)'(r_m1_v2) * (V2_W+CV_W)'(r_m1_cv);
        n_m2_p2 = P2_W'(r_coef_square) * P2_W'($signed({1'b0, r_m1_v2}));
    end

    always_ff @(posedge i_clk) begin
        if (m2_rdy) begin
            r_m2_v3  <= m2_cube[Q_FRAC+V3_W-1:Q_FRAC];
            r_m2_p1  <= r_m1_p1;
            r_m2_p2  <= n_m2_p2;
            r_m2_err <= r_m1_err;
        end
    end

    // m3: cubic term, partial sum
    logic signed [P3_W-1:0]  r_m3_p3, n_m3_p3;
    logic signed [S_W-1:0]   r_m3_s12, n_m3_s12;
    logic                    r_m3_err;

    always_comb begin
        n_m3_p3  = P3_W'(r_coef_cubic) * P3_W'($signed({1'b0, r_m2_v3}));
        n_m3_s12 = S_W'(r_m2_p1) + S_W'(r_m2_p2);
    end

    always_ff @(posedge i_clk) begin
        if (m3_rdy) begin
            r_m3_p3  <= n_m3_p3;
            r_m3_s12 <= n_m3_s12;
            r_m3_err <= r_m2_err;
        end
    end

    // m4: full q25 sum
    logic signed [S_W-1:0]   r_m4_s;
    logic                    r_m4_err;

    always_ff @(posedge i_clk) begin
        if (m4_rdy) begin
            r_m4_s   <= S_W'(r_m3_p3) + r_m3_s12;
            r_m4_err <= r_m3_err;
        end
    end

    // output register: clamp, saturate, whole ppm
    logic [PPM_W-1:0]  r_out_ppm, n_out_ppm;
    t_status           r_out_status, n_out_status;

    always_comb begin
        priority if (r_m4_err) begin
            n_out_ppm    = '0;
            n_out_status = ST_BAD_FACTOR;
        end else if (r_m4_s[S_W-1]) begin
            n_out_ppm    = '0;
            n_out_status = ST_CLAMP_ZERO;
        end else if (|r_m4_s[S_W-2:PPM_SHIFT+PPM_W]) begin
            n_out_ppm    = PPM_MAX;
            n_out_status = ST_SAT_HIGH;
        end else begin
            n_out_ppm    = r_m4_s[PPM_SHIFT+PPM_W-1:PPM_SHIFT];
            n_out_status = ST_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_out_ppm    <= n_out_ppm;
            r_out_status <= n_out_status;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_tds_ppm   = r_out_ppm;
    assign o_status    = r_out_status;

endmodule

[design/tdsc_div.sv]
// pipelined restoring divider, one quotient bit per stage
module tdsc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tdsc_pkg::DV_W-1:0]      i_rem,
    input  logic [tdsc_pkg::DV_W-1:0]      i_dvsr,
    input  logic [tdsc_pkg::DIV_Q-1:0]     i_feed,
    input  tdsc_pkg::t_div_tag             i_tag,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tdsc_pkg::DIV_Q-1:0]     o_quot,
    output tdsc_pkg::t_div_tag             o_tag
);
    import tdsc_pkg::*;

    logic [DIV_Q-1:0] r_vld;
    logic [DIV_Q:0]   rdy;
    logic [DV_W-1:0]  r_rem  [DIV_Q-1];
    logic [DV_W-1:0]  r_dvsr [DIV_Q-1];
    logic [DIV_Q-1:0] r_nq   [DIV_Q];
    t_div_tag         r_tag  [DIV_Q];

    logic [DIV_Q-1:0] s_vld;
    logic [DV_W-1:0]  s_rem  [DIV_Q];
    logic [DV_W-1:0]  s_dvsr [DIV_Q];
    logic [DIV_Q-1:0] s_nq   [DIV_Q];
    t_div_tag         s_tag  [DIV_Q];

    assign rdy[DIV_Q] = i_ready;
    assign o_ready = rdy[0];

    genvar g;
    generate
        for (g = 0; g < DIV_Q; g++) begin : g_stage
            logic [DV_W:0] w_t;
            logic          w_ge;

            if (g == 0) begin : g_src_in
                assign s_vld[g]  = i_valid;
                assign s_rem[g]  = i_rem;
                assign s_dvsr[g] = i_dvsr;
                assign s_nq[g]   = i_feed;
                assign s_tag[g]  = i_tag;
            end else begin : g_src_prev
                assign s_vld[g]  = r_vld[g-1];
                assign s_rem[g]  = r_rem[g-1];
                assign s_dvsr[g] = r_dvsr[g-1];
                assign s_nq[g]   = r_nq[g-1];
                assign s_tag[g]  = r_tag[g-1];
            end

            assign rdy[g] = !r_vld[g] || rdy[g+1];

            // bring down the next dividend bit from the top of the shift word
            assign w_t  = {s_rem[g], s_nq[g][DIV_Q-1]};
            assign w_ge = w_t >= {1'b0, s_dvsr[g]};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (rdy[g]) begin
                    r_vld[g] <= s_vld[g];
                end
            end

            // feed bits leave at the top as quotient bits enter at the bottom
            always_ff @(posedge i_clk) begin
                if (rdy[g]) begin
                    r_nq[g]  <= {s_nq[g][DIV_Q-2:0], w_ge};
                    r_tag[g] <= s_tag[g];
                end
            end

            if (g < DIV_Q-1) begin : g_rem
                logic [DV_W:0] w_diff;

                assign w_diff = w_t - {1'b0, s_dvsr[g]};

                always_ff @(posedge i_clk) begin
                    if (rdy[g]) begin
                        r_rem[g]  <= w_ge ? w_diff[DV_W-1:0] : w_t[DV_W-1:0];
                        r_dvsr[g] <= s_dvsr[g];
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[DIV_Q-1];
    assign o_quot  = r_nq[DIV_Q-1];
    assign o_tag   = r_tag[DIV_Q-1];

endmodule
